>>> rtl/cfc_pkg.sv
// Shared types, constants and helpers for the circle constraint force block.
// No dependencies; cfc_lambda, cfc_accel and the top level import this package.
package cfc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam logic [31:0] MASS_RESET = 32'h0001_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   // input word: one particle
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] applied_x;
      logic signed [31:0] applied_y;
      logic signed [31:0] applied_z;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [31:0] constraint_x;
      logic signed [31:0] constraint_y;
      logic signed [31:0] constraint_z;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic               degenerate;
      logic               saturated;
   } rsp_word_type;

   // per-item data that rides along with lambda; lane 0 is x
   typedef struct packed {
      logic             degen;
      logic             lam_neg;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] frc;
   } lam_side_type;

   // magnitude of a signed 32-bit value (fits 32 bits unsigned)
   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // clamp sign/magnitude to signed 32 bits; returns {sat, value}
   function automatic logic [32:0] clamp32(input logic over, input logic [31:0] mag,
                                           input logic neg);
      logic sat;
      logic [31:0] val;
      sat = over | (neg ? (mag > Q_MIN) : (mag > Q_MAX));
      if (sat) val = neg ? Q_MIN : Q_MAX;
      else     val = neg ? (~mag + 32'd1) : mag;
      return {sat, val};
   endfunction

endpackage

>>> rtl/cfc_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, plus an
// overflow flag for quotients of 2^QUO_W or more. Depends on no other file.
module cfc_div_pipe #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32,
   parameter int QUO_W = 32,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_side,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic             out_ovf,
   output logic [SB_W-1:0]  out_side
);
   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic             valid_ff [0:QUO_W];
   logic             ovf_ff   [0:QUO_W];
   logic [DEN_W-1:0] rem_ff   [0:QUO_W];
   logic [QUO_W-1:0] nb_ff    [0:QUO_W];
   logic [QUO_W-1:0] quo_ff   [0:QUO_W];
   logic [DEN_W-1:0] den_ff   [0:QUO_W];
   logic [SB_W-1:0]  side_ff  [0:QUO_W];

   logic [CMP_W-1:0] num_ext;
   logic [CMP_W-1:0] lim_ext;
   logic             ovf_in;
   logic [DEN_W-1:0] rem_in;

   // entry: overflow test and top remainder
   always_comb begin
      num_ext = CMP_W'(in_num);
      lim_ext = CMP_W'(in_den) << QUO_W;
      ovf_in  = num_ext >= lim_ext;
      rem_in  = ovf_in ? '0 : DEN_W'(num_ext >> QUO_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0]  <= ovf_in;
         rem_ff[0]  <= rem_in;
         nb_ff[0]   <= in_num[QUO_W-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   // one subtract-and-compare per stage
   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      logic [DEN_W:0] r2;
      logic           ge;
      assign r2 = {rem_ff[k-1], nb_ff[k-1][QUO_W-1]};
      assign ge = r2 >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ovf_ff[k]  <= ovf_ff[k-1];
            rem_ff[k]  <= ge ? DEN_W'(r2 - {1'b0, den_ff[k-1]}) : r2[DEN_W-1:0];
            nb_ff[k]   <= nb_ff[k-1] << 1;
            quo_ff[k]  <= {quo_ff[k-1][QUO_W-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

>>> rtl/cfc_lambda.sv
// Lambda front end: dot products, numerator, pipelined divide and cap.
// Depends on cfc_pkg and cfc_div_pipe.
module cfc_lambda #(
   parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEFAULT,
   parameter int LAM_W     = 33 + FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  cfc_pkg::req_word_type in_word,
   input  logic [31:0]           mass,
   output logic                  out_valid,
   output logic [LAM_W-1:0]      out_lam,
   output cfc_pkg::lam_side_type out_side
);
   import cfc_pkg::*;

   localparam int FX_W   = 66;
   localparam int MAG_W  = ((FRAC_BITS + 64 > 96) ? FRAC_BITS + 64 : 96) + 1;
   localparam int SNUM_W = MAG_W + 1;
   localparam int SB_W   = $bits(lam_side_type);

   // stage 1: nine products
   lam_side_type side_in, s1_side_ff;
   logic [2:0][63:0] fx_p_in, vv_p_in, xx_p_in;
   logic [2:0][63:0] fx_p_ff, vv_p_ff, xx_p_ff;
   logic s1_valid_ff;

   always_comb begin
      side_in.degen   = 1'b0;
      side_in.lam_neg = 1'b0;
      side_in.pos = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
      side_in.frc = {in_word.applied_z, in_word.applied_y, in_word.applied_x};
   end

   logic [2:0][31:0] vel_in;
   assign vel_in = {in_word.vel_z, in_word.vel_y, in_word.vel_x};

   for (genvar i = 0; i < 3; i++) begin : g_prod
      logic signed [63:0] fx_s;
      logic [31:0] av, ax;
      logic [63:0] vsq, xsq;
      assign fx_s = $signed(side_in.frc[i]) * $signed(side_in.pos[i]);
      assign av   = abs32(vel_in[i]);
      assign ax   = abs32(side_in.pos[i]);
      assign vsq  = av * av;
      assign xsq  = ax * ax;
      assign fx_p_in[i] = fx_s;
      assign vv_p_in[i] = vsq;
      assign xx_p_in[i] = xsq;
   end

   // stage 2: sums
   logic signed [FX_W-1:0] fx_in, fx2_ff, fx3_ff;
   logic [63:0] vv_in, vv2_ff, xx_in, xx2_ff, xx3_ff, xx4_ff;
   lam_side_type s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff;
   logic s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   always_comb begin
      fx_in = FX_W'($signed(fx_p_ff[0])) + FX_W'($signed(fx_p_ff[1]))
            + FX_W'($signed(fx_p_ff[2]));
      vv_in = vv_p_ff[0] + vv_p_ff[1] + vv_p_ff[2];
      xx_in = xx_p_ff[0] + xx_p_ff[1] + xx_p_ff[2];
   end

   // stage 3: mass times v.v in two halves
   logic [63:0] mv_lo_in, mv_hi_in, mv_lo_ff, mv_hi_ff;
   lam_side_type s3_side_in;
   assign mv_lo_in = mass * vv2_ff[31:0];
   assign mv_hi_in = mass * vv2_ff[63:32];
   always_comb begin
      s3_side_in       = s2_side_ff;
      s3_side_in.degen = (xx2_ff == '0);
   end

   // stage 4: signed numerator
   logic [95:0] mv;
   logic signed [SNUM_W-1:0] num_in, num_ff;
   assign mv     = {32'b0, mv_lo_ff} + {mv_hi_ff, 32'b0};
   assign num_in = -(SNUM_W'(fx3_ff) <<< FRAC_BITS) - $signed(SNUM_W'(mv));

   // stage 5: sign and magnitude
   logic [MAG_W-1:0] mag_in, mag_ff;
   lam_side_type s5_side_in;
   assign mag_in = num_ff[SNUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   always_comb begin
      s5_side_in         = s4_side_ff;
      s5_side_in.lam_neg = num_ff[SNUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_p_ff    <= fx_p_in;
         vv_p_ff    <= vv_p_in;
         xx_p_ff    <= xx_p_in;
         s1_side_ff <= side_in;
         fx2_ff     <= fx_in;
         vv2_ff     <= vv_in;
         xx2_ff     <= xx_in;
         s2_side_ff <= s1_side_ff;
         mv_lo_ff   <= mv_lo_in;
         mv_hi_ff   <= mv_hi_in;
         fx3_ff     <= fx2_ff;
         xx3_ff     <= xx2_ff;
         s3_side_ff <= s3_side_in;
         num_ff     <= num_in;
         xx4_ff     <= xx3_ff;
         s4_side_ff <= s3_side_ff;
         mag_ff     <= mag_in;
         s5_side_ff <= s5_side_in;
      end
   end

   // divide |num| by x.x
   logic [63:0] xx5_ff;
   always_ff @(posedge clock) begin
      if (en) xx5_ff <= xx4_ff;
   end

   logic             dv_valid, dv_ovf;
   logic [LAM_W-1:0] dv_quo;
   logic [SB_W-1:0]  dv_side;

   cfc_div_pipe #(
      .NUM_W (MAG_W),
      .DEN_W (64),
      .QUO_W (LAM_W),
      .SB_W  (SB_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_num    (mag_ff),
      .in_den    (xx5_ff),
      .in_side   (s5_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf),
      .out_side  (dv_side)
   );

   // cap lambda, force zero at the origin
   localparam logic [LAM_W-1:0] CAP = LAM_W'(1) << (32 + FRAC_BITS);
   lam_side_type dv_s, sel_side_in, lam_side_ff;
   logic [LAM_W-1:0] lam_in, lam_ff;
   logic lam_valid_ff;

   always_comb begin
      dv_s = lam_side_type'(dv_side);
      sel_side_in = dv_s;
      sel_side_in.lam_neg = dv_s.lam_neg & ~dv_s.degen;
      if (dv_s.degen)                    lam_in = '0;
      else if (dv_ovf || (dv_quo > CAP)) lam_in = CAP;
      else                               lam_in = dv_quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_valid_ff <= 1'b0;
      end else if (en) begin
         lam_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lam_ff      <= lam_in;
         lam_side_ff <= sel_side_in;
      end
   end

   assign out_valid = lam_valid_ff;
   assign out_lam   = lam_ff;
   assign out_side  = lam_side_ff;

   // lambda never exceeds the cap, and is zero at the origin
   a_lam_cap: assert property (@(posedge clock) disable iff (reset)
      lam_valid_ff |-> lam_ff <= CAP)
      else $error("lambda above cap");
   a_lam_degen: assert property (@(posedge clock) disable iff (reset)
      lam_valid_ff && lam_side_ff.degen |-> lam_ff == '0 && !lam_side_ff.lam_neg)
      else $error("nonzero lambda at origin");
   a_degen_xx: assert property (@(posedge clock) disable iff (reset)
      en && s2_valid_ff && xx2_ff == '0 |=> s3_side_ff.degen)
      else $error("degenerate flag lost");

endmodule

>>> rtl/cfc_accel.sv
// Back end: constraint force lambda*x, total force and divide by mass.
// Depends on cfc_pkg and cfc_div_pipe.
module cfc_accel #(
   parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEFAULT,
   parameter int LAM_W     = 33 + FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [LAM_W-1:0]      in_lam,
   input  cfc_pkg::lam_side_type in_side,
   input  logic [31:0]           mass,
   output logic                  out_valid,
   output cfc_pkg::rsp_word_type out_word
);
   import cfc_pkg::*;

   localparam int HI_W = LAM_W - 32;
   localparam int P_W  = LAM_W + 32;
   localparam int TM_W = 33 + FRAC_BITS;

   // stage A: partial products lambda*|x|
   logic [2:0][63:0]      plo_in, plo_ff;
   logic [2:0][HI_W+31:0] phi_in, phi_ff;
   logic [2:0]            neg_in, neg_ff;
   logic [2:0][31:0]      frc_a_ff;
   logic                  degen_a_ff, va_ff;

   for (genvar i = 0; i < 3; i++) begin : g_pp
      logic [31:0] ax;
      logic [63:0] lo_p;
      logic [HI_W+31:0] hi_p;
      assign ax   = abs32(in_side.pos[i]);
      assign lo_p = in_lam[31:0] * ax;
      assign hi_p = in_lam[LAM_W-1:32] * ax;
      assign plo_in[i] = lo_p;
      assign phi_in[i] = hi_p;
      assign neg_in[i] = in_side.lam_neg ^ in_side.pos[i][31];
   end

   // stage B: sum, scale and clamp constraint force
   logic [2:0][31:0] c_in, c_b_ff;
   logic [2:0]       satc_in;
   logic             satc_b_ff, degen_b_ff, vb_ff;
   logic [2:0][31:0] frc_b_ff;

   for (genvar i = 0; i < 3; i++) begin : g_cf
      logic [P_W-1:0] p, ps;
      logic [32:0]    cl;
      assign p  = P_W'(plo_ff[i]) + (P_W'(phi_ff[i]) << 32);
      assign ps = p >> FRAC_BITS;
      assign cl = clamp32(|ps[P_W-1:32], ps[31:0], neg_ff[i]);
      assign c_in[i]    = cl[31:0];
      assign satc_in[i] = cl[32];
   end

   // stage C: total force, magnitude scaled up
   logic [2:0][TM_W-1:0] tm_in, tm_ff;
   logic [2:0]           tneg_in, tneg_ff;
   logic [2:0][31:0]     c_c_ff;
   logic                 satc_c_ff, degen_c_ff, vc_ff;

   for (genvar i = 0; i < 3; i++) begin : g_tf
      logic signed [32:0] t;
      logic [32:0] tmag;
      assign t    = 33'($signed(frc_b_ff[i])) + 33'($signed(c_b_ff[i]));
      assign tmag = t[32] ? 33'(-t) : 33'(t);
      assign tm_in[i]   = TM_W'(tmag) << FRAC_BITS;
      assign tneg_in[i] = t[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         neg_ff     <= neg_in;
         frc_a_ff   <= in_side.frc;
         degen_a_ff <= in_side.degen;
         c_b_ff     <= c_in;
         satc_b_ff  <= |satc_in;
         frc_b_ff   <= frc_a_ff;
         degen_b_ff <= degen_a_ff;
         tm_ff      <= tm_in;
         tneg_ff    <= tneg_in;
         c_c_ff     <= c_b_ff;
         satc_c_ff  <= satc_b_ff;
         degen_c_ff <= degen_b_ff;
      end
   end

   // three divide lanes by mass; lane 0 carries the shared fields
   localparam int SB0_W = 96 + 3;
   logic [SB0_W-1:0] sb0_out;
   logic [2:0]       dv_valid, dv_ovf;
   logic [2:0][31:0] dv_quo;
   logic [1:0]       tneg12;

   cfc_div_pipe #(
      .NUM_W (TM_W), .DEN_W (32), .QUO_W (32), .SB_W (SB0_W)
   ) u_div0 (
      .clock (clock), .reset (reset), .en (en),
      .in_valid  (vc_ff),
      .in_num    (tm_ff[0]),
      .in_den    (mass),
      .in_side   ({c_c_ff, satc_c_ff, degen_c_ff, tneg_ff[0]}),
      .out_valid (dv_valid[0]),
      .out_quo   (dv_quo[0]),
      .out_ovf   (dv_ovf[0]),
      .out_side  (sb0_out)
   );

   for (genvar i = 1; i < 3; i++) begin : g_lane
      cfc_div_pipe #(
         .NUM_W (TM_W), .DEN_W (32), .QUO_W (32), .SB_W (1)
      ) u_div (
         .clock (clock), .reset (reset), .en (en),
         .in_valid  (vc_ff),
         .in_num    (tm_ff[i]),
         .in_den    (mass),
         .in_side   (tneg_ff[i]),
         .out_valid (dv_valid[i]),
         .out_quo   (dv_quo[i]),
         .out_ovf   (dv_ovf[i]),
         .out_side  (tneg12[i-1])
      );
   end

   // final stage: clamp accelerations, gather flags
   logic [2:0][31:0] c_out;
   logic             satc_out, degen_out;
   logic [2:0]       tneg_out, sata;
   logic [2:0][31:0] a_out;
   rsp_word_type     word_in, word_ff;
   logic             vo_ff;

   assign {c_out, satc_out, degen_out, tneg_out[0]} = sb0_out;
   assign tneg_out[2:1] = tneg12;

   for (genvar i = 0; i < 3; i++) begin : g_acl
      logic [32:0] cl;
      assign cl = clamp32(dv_ovf[i], dv_quo[i], tneg_out[i]);
      assign a_out[i] = cl[31:0];
      assign sata[i]  = cl[32];
   end

   always_comb begin
      word_in.constraint_x = c_out[0];
      word_in.constraint_y = c_out[1];
      word_in.constraint_z = c_out[2];
      word_in.accel_x      = a_out[0];
      word_in.accel_y      = a_out[1];
      word_in.accel_z      = a_out[2];
      word_in.degenerate   = degen_out;
      word_in.saturated    = satc_out | (|sata);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= dv_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) word_ff <= word_in;
   end

   assign out_valid = vo_ff;
   assign out_word  = word_ff;

   // the three lanes march in step
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] == dv_valid[1] && dv_valid[1] == dv_valid[2])
      else $error("divide lanes out of step");
   a_degen_c: assert property (@(posedge clock) disable iff (reset)
      vb_ff && degen_b_ff |-> c_b_ff == '0 && !satc_b_ff)
      else $error("constraint force nonzero at origin");

endmodule

>>> rtl/circle_constraint_force_top.sv
// Top level of the circle constraint force block: mass register, pipeline
// and output skid. Depends on cfc_pkg, cfc_lambda and cfc_accel.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | req_word (pos, vel, applied force)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_word (constraint, accel, flags)
//  csr     | in        | csr_wr_en            | csr_wr_data (particle mass)
//
// One word per cycle sustained while rsp_stall stays low; the pipeline holds the
// bit-per-stage lambda divider (33 + FRAC_BITS stages) and the 32-stage mass
// dividers. Reset is synchronous and clears all valid bits and sets mass to 1.0.
// rsp_stall parks one word in the skid stage; req_stall is the registered skid
// full flag, so the pipeline freezes only once the skid holds a word.
module circle_constraint_force_top #(
   parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data
);
   import cfc_pkg::*;

   localparam int LAM_W = 33 + FRAC_BITS;

   // mass register; zero acts as one LSB
   logic [31:0] mass_ff, mass_eff;
   always_ff @(posedge clock) begin
      if (reset) mass_ff <= MASS_RESET;
      else if (csr_wr_en) mass_ff <= csr_wr_data;
   end
   assign mass_eff = (mass_ff == '0) ? 32'd1 : mass_ff;

   // pipeline advance
   logic skid_valid_ff, rsp_valid_ff, en;
   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   logic             lam_valid;
   logic [LAM_W-1:0] lam;
   lam_side_type     lam_side;
   logic             pipe_valid;
   rsp_word_type     pipe_word;

   cfc_lambda #(.FRAC_BITS (FRAC_BITS), .LAM_W (LAM_W)) u_lambda (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .mass      (mass_eff),
      .out_valid (lam_valid),
      .out_lam   (lam),
      .out_side  (lam_side)
   );

   cfc_accel #(.FRAC_BITS (FRAC_BITS), .LAM_W (LAM_W)) u_accel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (lam_valid),
      .in_lam    (lam),
      .in_side   (lam_side),
      .mass      (mass_eff),
      .out_valid (pipe_valid),
      .out_word  (pipe_word)
   );

   // output register plus skid word
   logic         pipe_take, rsp_free;
   rsp_word_type rsp_word_ff, skid_word_ff;
   assign pipe_take = en & pipe_valid;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff  <= skid_valid_ff | pipe_take;
         skid_valid_ff <= 1'b0;
      end else if (pipe_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_word_ff <= skid_valid_ff ? skid_word_ff : pipe_word;
      end else if (pipe_take) begin
         skid_word_ff <= pipe_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // skid only fills behind a stalled output word
   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without output word");
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while output free");
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid word not drained");

endmodule

>>> bench/circle_constraint_force_checker.sv
`timescale 1ns / 1ps
// Scoreboard for circle_constraint_force_top: follows the mass register, predicts
// each result word from the accepted request word and compares it field by field.
// Depends on cfc_pkg for the word types and the mass reset value.
module circle_constraint_force_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  cfc_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cfc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   output int                    fail_count,
   output int                    pending
);
   import cfc_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam logic [127:0] LAM_CAP = 128'd1 << (32 + FRAC);

   logic [31:0] mass_now;
   rsp_word_type expected_words[$];

   // saturate a sign/magnitude pair to signed 32 bits
   function automatic longint clamp_q(input logic [127:0] mag, input logic neg,
                                      inout logic sat);
      if (neg) begin
         if (mag > 128'h8000_0000) begin
            sat = 1'b1;
            return -64'sd2147483648;
         end
         return -longint'(mag[63:0]);
      end
      if (mag > 128'h7FFF_FFFF) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(mag[63:0]);
   endfunction

   function automatic rsp_word_type predict_force(input req_word_type w,
                                                  input logic [31:0] mass);
      longint pos[3], vel[3], frc[3], cval[3], aval[3], tot;
      logic [127:0] m, vv, xx, mag, lam, prod;
      logic signed [159:0] fx, num;
      logic neg_lam, sat, degen;
      rsp_word_type r;
      pos = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
      vel = '{longint'(w.vel_x), longint'(w.vel_y), longint'(w.vel_z)};
      frc = '{longint'(w.applied_x), longint'(w.applied_y), longint'(w.applied_z)};
      m = (mass == 0) ? 128'd1 : 128'(mass);
      fx = 0;
      vv = 0;
      xx = 0;
      neg_lam = 1'b0;
      sat = 1'b0;
      lam = 0;
      for (int i = 0; i < 3; i++) begin
         fx = fx + frc[i] * pos[i];
         mag = 128'(vel[i] < 0 ? -vel[i] : vel[i]);
         vv = vv + mag * mag;
         mag = 128'(pos[i] < 0 ? -pos[i] : pos[i]);
         xx = xx + mag * mag;
      end
      degen = (xx == 0);
      // lambda = (-(F.x) * 2^FRAC - m * v.v) / x.x, truncated, magnitude capped
      if (!degen) begin
         prod = m * vv;
         num = -(fx * (160'sd1 <<< FRAC)) - $signed({32'd0, prod});
         neg_lam = num < 0;
         mag = neg_lam ? 128'(-num) : 128'(num);
         lam = mag / xx;
         if (lam > LAM_CAP) lam = LAM_CAP;
      end
      for (int i = 0; i < 3; i++) begin
         prod = (lam * 128'(pos[i] < 0 ? -pos[i] : pos[i])) >> FRAC;
         cval[i] = clamp_q(prod, neg_lam != (pos[i] < 0), sat);
         tot = frc[i] + cval[i];
         mag = 128'(tot < 0 ? -tot : tot) << FRAC;
         aval[i] = clamp_q(mag / m, tot < 0, sat);
      end
      r.constraint_x = cval[0][31:0];
      r.constraint_y = cval[1][31:0];
      r.constraint_z = cval[2][31:0];
      r.accel_x = aval[0][31:0];
      r.accel_y = aval[1][31:0];
      r.accel_z = aval[2][31:0];
      r.degenerate = degen;
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      mass_now = MASS_RESET;
   end

   assign pending = expected_words.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         mass_now <= MASS_RESET;
         expected_words.delete();
      end else begin
         // request accepted: predict with the mass in force now
         if (req_valid && !req_stall)
            expected_words.push_back(predict_force(req_word, mass_now));
         if (csr_wr_en)
            mass_now <= csr_wr_data;
         // result accepted: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t result word with nothing expected", $time);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.constraint_x !== want.constraint_x)
                  report_mismatch("constraint_x", rsp_word.constraint_x, want.constraint_x);
               if (rsp_word.constraint_y !== want.constraint_y)
                  report_mismatch("constraint_y", rsp_word.constraint_y, want.constraint_y);
               if (rsp_word.constraint_z !== want.constraint_z)
                  report_mismatch("constraint_z", rsp_word.constraint_z, want.constraint_z);
               if (rsp_word.accel_x !== want.accel_x)
                  report_mismatch("accel_x", rsp_word.accel_x, want.accel_x);
               if (rsp_word.accel_y !== want.accel_y)
                  report_mismatch("accel_y", rsp_word.accel_y, want.accel_y);
               if (rsp_word.accel_z !== want.accel_z)
                  report_mismatch("accel_z", rsp_word.accel_z, want.accel_z);
               if (rsp_word.degenerate !== want.degenerate)
                  report_mismatch("degenerate", 32'(rsp_word.degenerate),
                                  32'(want.degenerate));
               if (rsp_word.saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_word.saturated),
                                  32'(want.saturated));
            end
         end
      end
   end

endmodule

>>> bench/circle_constraint_force_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for circle_constraint_force_top: directed and random particle
// words under several masses, with random gaps on both channels.
// Depends on cfc_pkg, the block and circle_constraint_force_checker.
module circle_constraint_force_top_test;
   import cfc_pkg::*;

   localparam int DRAIN_CYCLES = 200;
   localparam int IDLE_LIMIT = 5000;
   localparam int WORDS_PER_MASS = 140;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_wr_en;
   logic [31:0] csr_wr_data;
   int fail_count;
   int pending;
   int idle_cycles = 0;
   int rsp_hold = 0;
   bit rsp_eager;
   bit rsp_taken;
   bit req_eager;

   circle_constraint_force_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   circle_constraint_force_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: cycles in which neither channel moves a word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: note each accepted result word
   always @(posedge clock) begin
      rsp_taken <= rsp_valid && !rsp_stall;
   end

   // random stall run before each result word, with eager stretches
   always @(negedge clock) begin
      int hold;
      hold = rsp_hold;
      if (rsp_taken) begin
         if ($urandom_range(0, 99) < 3) rsp_eager = ~rsp_eager;
         hold = rsp_eager ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end
   end

   function automatic logic [31:0] rand_q(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         default: return '0;
      endcase
   endfunction

   function automatic req_word_type rand_particle();
      req_word_type w;
      int kind;
      kind = $urandom_range(0, 9);
      // mostly physical sizes, some full-range noise and a few at the origin
      kind = (kind < 5) ? 1 : (kind < 7) ? 2 : (kind < 9) ? 0 : 3;
      w.pos_x = rand_q(kind);
      w.pos_y = rand_q($urandom_range(0, 5) == 0 ? 3 : kind);
      w.pos_z = rand_q($urandom_range(0, 5) == 0 ? 3 : kind);
      kind = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2);
      w.vel_x = rand_q(kind);
      w.vel_y = rand_q(kind);
      w.vel_z = rand_q(kind);
      kind = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3);
      w.applied_x = rand_q(kind);
      w.applied_y = rand_q(kind);
      w.applied_z = rand_q(kind);
      return w;
   endfunction

   // offer one word after a random gap and hold it until accepted
   task automatic send_word(input req_word_type w);
      int gap;
      if ($urandom_range(0, 99) < 3) req_eager = ~req_eager;
      gap = req_eager ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // wait out every result and the tail of the pipeline, then write the mass
   task automatic set_mass(input logic [31:0] mass);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mass;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_directed();
      req_word_type w;
      logic [31:0] extremes[4];
      extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
      // position at origin
      w = '0;
      w.applied_x = 32'h0003_0000;
      w.applied_y = 32'hFFFE_0000;
      w.vel_x = 32'h0001_0000;
      send_word(w);
      // all fields at one extreme
      foreach (extremes[i]) begin
         w = {9{extremes[i]}};
         send_word(w);
      end
      // unit circle at rest and in motion
      w = '0;
      w.pos_x = 32'h0001_0000;
      send_word(w);
      w.vel_y = 32'h0001_0000;
      send_word(w);
      w.applied_x = 32'hFFFF_0000;
      w.applied_y = 32'h0000_8000;
      send_word(w);
      // tiny position, huge velocity: lambda cap and clamping
      w = '0;
      w.pos_z = 32'h0000_0001;
      w.vel_x = 32'h7FFF_FFFF;
      w.vel_y = 32'h8000_0000;
      send_word(w);
      // mixed extremes so every bit toggles
      w = {32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
           32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001};
      send_word(w);
      w = {32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
           32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
      send_word(w);
      repeat (8) send_word(rand_particle());
   endtask

   initial begin
      logic [31:0] masses[7];
      masses = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                 32'h0003_4000, 32'h0000_0100, 32'h0001_0000};
      masses[4] = $urandom_range(1, 32'h00FF_FFFF);
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      req_eager = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // reset mass first, then each setting in turn
      send_directed();
      foreach (masses[k]) begin
         if (k > 0) begin
            set_mass(masses[k]);
            send_directed();
         end
         repeat (WORDS_PER_MASS - (k == 0 ? 0 : 30)) send_word(rand_particle());
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/cfc_pkg.sv
rtl/cfc_div_pipe.sv
rtl/cfc_lambda.sv
rtl/cfc_accel.sv
rtl/circle_constraint_force_top.sv
bench/circle_constraint_force_checker.sv
bench/circle_constraint_force_top_test.sv
